>>> src/psra_pkg.sv
package psra_pkg;

    // Number of table entries; must be a power of two from 2 to 65536.
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    // The index is taken from bits starting at this position of the product.
    localparam int HASH_SHIFT = 16;

    localparam logic [15:0] THRESHOLD_RESET = 16'd50;
    localparam logic [15:0] WINDOW_RESET    = 16'd10;

    typedef enum logic {
        CFG_ALARM_THRESHOLD = 1'b0,
        CFG_WINDOW_SECONDS  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic        alert;
        logic [31:0] alert_source;
        logic [15:0] packets_seen;
        logic        tracked;
    } t_out_item;

    typedef struct packed {
        logic             tracked;
        logic [31:0]      source_address;
        logic [31:0]      now_seconds;
        logic [IDX_W-1:0] index;
    } t_job;

    typedef struct packed {
        logic        valid;
        logic [31:0] source;
        logic [31:0] window_start;
        logic [15:0] count;
    } t_entry;

endpackage

>>> src/per_source_packet_rate_alarm_top.sv
// Per-source packet rate alarm: one result beat for every input beat, in order.
// A result passes the front register, the job queue, the table read register and the
// result buffer; the back starts a new beat only after writing back the last one.
// Reset is synchronous and active low; after it, a clearing pass over all
// TABLE_ENTRIES entries clears the valid bits, with full held high.
// Configuration writes are taken at any time, also during the clearing pass.
module per_source_packet_rate_alarm_top
    import psra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // The front stage registers each beat, hashes the source address and
    // marks whether the protocol is counted. The job queue between front and
    // back lets the front keep accepting while the back is busy with the
    // read-modify-write of one table entry, or waits on a full result buffer.
    logic w_q_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    logic w_clearing;
    t_job w_q_in;
    t_job w_q_out;

    psra_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .i_clearing (w_clearing),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    psra_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out)
    );

    // The back part owns the window table, the configuration registers and a
    // two-beat result buffer, so a single waiting result does not block new work.
    psra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_clearing  (w_clearing),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

>>> src/psra_front.sv
module psra_front
    import psra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in,
    input  logic     i_clearing,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_job     o_q_data
);

    logic        r_valid;
    logic        n_valid;
    t_in_item    r_item;
    logic [31:0] w_prod;
    logic        w_accept;

    // The stage drains into the queue whenever the queue has room.
    assign o_q_push = r_valid && !i_q_full;
    assign full     = i_clearing || (r_valid && i_q_full);
    assign w_accept = push && !full;

    always_comb begin
        n_valid = r_valid;
        if (o_q_push) begin
            n_valid = 1'b0;
        end
        if (w_accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_item <= i_in;
        end
    end

    assign w_prod = r_item.source_address * HASH_MULT;

    always_comb begin
        o_q_data.tracked        = (r_item.ip_protocol == PROTO_ICMP) ||
                                  (r_item.ip_protocol == PROTO_TCP);
        o_q_data.source_address = r_item.source_address;
        o_q_data.now_seconds    = r_item.now_seconds;
        o_q_data.index          = w_prod[HASH_SHIFT +: IDX_W];
    end

endmodule

>>> src/psra_job_queue.sv
module psra_job_queue
    import psra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/psra_back.sv
module psra_back
    import psra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_empty,
    input  t_job        i_q_data,
    output logic        o_q_pop,
    output logic        o_clearing,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [15:0]      r_threshold;
    logic [15:0]      r_window;
    logic [IDX_W-1:0] r_clr_addr;
    t_job             r_job;
    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rdata;

    t_out_item        r_obuf [2];
    logic             r_owr_ptr;
    logic             r_ord_ptr;
    logic [1:0]       r_ocount;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    t_out_item        w_result;
    logic             w_opush;
    logic             w_opop;
    logic             w_hit;
    logic             w_inside;
    logic             w_alert;
    logic [15:0]      w_cnt_inc;
    logic [31:0]      w_elapsed;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty && (r_ocount != 2'd2);
    assign w_opush    = (r_state == S_EXEC);
    assign empty      = (r_ocount == 2'd0);
    assign w_opop     = pop && !empty;
    assign o_out      = r_obuf[r_ord_ptr];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_q_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Update of the looked-up entry and its verdict, or a zero write in the clearing pass.
    always_comb begin
        w_hit     = r_rdata.valid && (r_rdata.source == r_job.source_address);
        w_cnt_inc = (r_rdata.count != COUNT_MAX) ? r_rdata.count + 16'd1 : r_rdata.count;
        w_elapsed = r_job.now_seconds - r_rdata.window_start;
        w_inside  = (w_elapsed <= {16'd0, r_window});
        w_alert   = r_job.tracked && w_hit && w_inside && (w_cnt_inc >= r_threshold);

        w_wdata.valid        = 1'b1;
        w_wdata.source       = r_job.source_address;
        w_wdata.window_start = r_job.now_seconds;
        w_wdata.count        = 16'd1;
        w_result.alert        = w_alert;
        w_result.alert_source = r_job.source_address;
        w_result.packets_seen = 16'd1;
        w_result.tracked      = r_job.tracked;

        if (!r_job.tracked) begin
            w_result.packets_seen = 16'd0;
        end else if (w_hit && w_alert) begin
            w_wdata.count         = 16'd0;
            w_result.packets_seen = w_cnt_inc;
        end else if (w_hit && w_inside) begin
            w_wdata.window_start  = r_rdata.window_start;
            w_wdata.count         = w_cnt_inc;
            w_result.packets_seen = w_cnt_inc;
        end

        w_we    = (r_state == S_EXEC) && r_job.tracked;
        w_waddr = r_job.index;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (o_q_pop) begin
            r_rdata <= r_mem[i_q_data.index];
            r_job   <= i_q_data;
        end
        if (w_opush) begin
            r_obuf[r_owr_ptr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_threshold <= THRESHOLD_RESET;
            r_window    <= WINDOW_RESET;
            r_owr_ptr   <= 1'b0;
            r_ord_ptr   <= 1'b0;
            r_ocount    <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALARM_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_WINDOW_SECONDS:  r_window    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_opush) begin
                r_owr_ptr <= ~r_owr_ptr;
            end
            if (w_opop) begin
                r_ord_ptr <= ~r_ord_ptr;
            end
            if (w_opush && !w_opop) begin
                r_ocount <= r_ocount + 2'd1;
            end else if (w_opop && !w_opush) begin
                r_ocount <= r_ocount - 2'd1;
            end
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psra_pkg::*;

    // Extra wait after the last verdict, so the block has settled before a register
    // write or the end.
    localparam int SETTLE_CYCLES = 8;
    // The slowest correct run spans the clearing pass, then about 830 beats
    // plus idling bursts on both sides.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam logic [31:0] ALIAS_BIT = 32'h0400_0000;

    // Scoreboard: keeps its own copy of the rate table and registers, predicts
    // the verdict of every packet taken by the block, and checks the verdicts
    // that come out in order.
    class rate_scoreboard;
        logic [15:0] threshold;
        logic [15:0] window_len;
        bit          slot_valid  [TABLE_ENTRIES];
        logic [31:0] slot_source [TABLE_ENTRIES];
        logic [31:0] slot_start  [TABLE_ENTRIES];
        logic [15:0] slot_count  [TABLE_ENTRIES];
        t_out_item   expected_verdicts[$];
        int          mismatches;

        function new();
            threshold  = THRESHOLD_RESET;
            window_len = WINDOW_RESET;
            mismatches = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        // The slot is taken from the upper half of the multiplicative hash.
        function int unsigned table_slot(logic [31:0] addr);
            logic [31:0] prod;
            prod = addr * HASH_MULT;
            return (prod >> HASH_SHIFT) % TABLE_ENTRIES;
        endfunction

        function void note_packet(t_in_item pkt);
            t_out_item   v;
            int unsigned s;
            logic [15:0] cnt;
            logic [31:0] elapsed;
            bit          in_window;
            v.alert        = 1'b0;
            v.alert_source = pkt.source_address;
            v.packets_seen = 16'd0;
            v.tracked      = 1'b0;
            if (pkt.ip_protocol == PROTO_ICMP || pkt.ip_protocol == PROTO_TCP) begin
                s = table_slot(pkt.source_address);
                v.tracked = 1'b1;
                if (!slot_valid[s] || slot_source[s] != pkt.source_address) begin
                    // New source, or another source evicts the one held here.
                    slot_valid[s]  = 1'b1;
                    slot_source[s] = pkt.source_address;
                    slot_start[s]  = pkt.now_seconds;
                    slot_count[s]  = 16'd1;
                    v.packets_seen = 16'd1;
                end else begin
                    cnt = slot_count[s];
                    if (cnt != COUNT_MAX) cnt = cnt + 16'd1;
                    elapsed   = pkt.now_seconds - slot_start[s];
                    in_window = (elapsed <= {16'd0, window_len});
                    if (in_window && cnt >= threshold) begin
                        v.alert        = 1'b1;
                        v.packets_seen = cnt;
                        slot_start[s]  = pkt.now_seconds;
                        slot_count[s]  = 16'd0;
                    end else if (!in_window) begin
                        slot_start[s]  = pkt.now_seconds;
                        slot_count[s]  = 16'd1;
                        v.packets_seen = 16'd1;
                    end else begin
                        slot_count[s]  = cnt;
                        v.packets_seen = cnt;
                    end
                end
            end
            expected_verdicts.push_back(v);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_verdict(t_out_item got);
            t_out_item want;
            if (expected_verdicts.size() == 0) begin
                report($sformatf("verdict for %h with no packet waiting", got.alert_source));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.alert !== want.alert)
                report($sformatf("%h alert %b, want %b",
                                 want.alert_source, got.alert, want.alert));
            if (got.alert_source !== want.alert_source)
                report($sformatf("alert_source %h, want %h",
                                 got.alert_source, want.alert_source));
            if (got.packets_seen !== want.packets_seen)
                report($sformatf("%h packets_seen %0d, want %0d",
                                 want.alert_source, got.packets_seen, want.packets_seen));
            if (got.tracked !== want.tracked)
                report($sformatf("%h tracked %b, want %b",
                                 want.alert_source, got.tracked, want.tracked));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_we = 1'b0;
    t_cfg_index i_cfg_index = CFG_ALARM_THRESHOLD;
    logic [15:0] i_cfg_data = 16'd0;

    rate_scoreboard sb = new();

    // Both sides idle in random bursts while this is set.
    bit          idling = 1'b1;
    int          cycles = 0;
    logic [31:0] src_pool [6];
    logic [31:0] now_clock = 32'd0;

    per_source_packet_rate_alarm_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side: every beat taken off the block is checked against the oldest
    // prediction. Stalls come in random bursts while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.check_verdict(o_out);
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall_left = int'($urandom_range(1, 14)) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_in_item make_packet(logic [7:0] proto, logic [31:0] addr,
                                             logic [31:0] t);
        t_in_item p;
        p.ip_protocol    = proto;
        p.source_address = addr;
        p.now_seconds    = t;
        return p;
    endfunction

    // Offers one beat and returns at the edge that takes it. Push stays high
    // afterwards, so back-to-back beats do not drop it outside idle bursts.
    task automatic send_packet(t_in_item pkt);
        if (idling && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= pkt;
        do @(posedge i_clk); while (full);
        sb.note_packet(pkt);
    endtask

    // Waits until every verdict is out and the pipeline has settled.
    task automatic drain;
        push <= 1'b0;
        while (sb.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the threshold register, then the window register, while the block is idle.
    task automatic write_config(logic [15:0] thr, logic [15:0] win);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ALARM_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_WINDOW_SECONDS;
        i_cfg_data  <= win;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.threshold  = thr;
        sb.window_len = win;
    endtask

    task automatic directed_packets;
        logic [31:0] a;
        logic [31:0] b;
        a = 32'h0A00_0001;
        // Flipping bit 26 only moves bits 26 and up of the hash product, so the
        // two sources share a table slot.
        b = a ^ ALIAS_BIT;
        write_config(16'd3, 16'd10);
        // Protocols that are not counted, with the extreme field values.
        send_packet(make_packet(8'd0, a, 32'd0));
        send_packet(make_packet(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_packet(make_packet(8'd17, 32'h0, 32'd7));
        send_packet(make_packet(8'd7, a, 32'd9));
        send_packet(make_packet(8'd2, a, 32'd9));
        // First packet, counting up to the threshold, then a count from zero.
        send_packet(make_packet(PROTO_ICMP, a, 32'd100));
        send_packet(make_packet(PROTO_TCP, a, 32'd101));
        send_packet(make_packet(PROTO_ICMP, a, 32'd102));
        send_packet(make_packet(PROTO_ICMP, a, 32'd103));
        // Window long gone: a fresh window with count one.
        send_packet(make_packet(PROTO_ICMP, a, 32'd200));
        // Two sources fighting over one slot.
        send_packet(make_packet(PROTO_TCP, b, 32'd201));
        send_packet(make_packet(PROTO_TCP, a, 32'd202));
        // Elapsed time that wraps past 2^32, inside and then outside the window.
        send_packet(make_packet(PROTO_ICMP, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        send_packet(make_packet(PROTO_ICMP, 32'hFFFF_FFFF, 32'd3));
        send_packet(make_packet(PROTO_ICMP, 32'hFFFF_FFFF, 32'd13));
        // Elapsed exactly equal to the window still counts as inside.
        send_packet(make_packet(PROTO_TCP, 32'h0, 32'd0));
        send_packet(make_packet(PROTO_TCP, 32'h0, 32'd10));
        send_packet(make_packet(PROTO_TCP, 32'h0, 32'd21));
        // Threshold one with a zero-length window: the first packet never alerts.
        write_config(16'd1, 16'd0);
        send_packet(make_packet(PROTO_ICMP, 32'h1234_5678, 32'd5));
        send_packet(make_packet(PROTO_ICMP, 32'h1234_5678, 32'd5));
        send_packet(make_packet(PROTO_ICMP, 32'h1234_5678, 32'd6));
        // Threshold zero with the longest window.
        write_config(16'd0, 16'hFFFF);
        send_packet(make_packet(PROTO_TCP, 32'h8000_0000, 32'd0));
        send_packet(make_packet(PROTO_TCP, 32'h8000_0000, 32'd65535));
        send_packet(make_packet(PROTO_TCP, 32'h8000_0000, 32'd131071));
    endtask

    // Mostly well-formed traffic: a handful of sources (pairs of them aliasing
    // onto one slot) with time creeping forward, so windows fill up and alert.
    // The rest is uncounted protocols, stray sources and jumps in time.
    function automatic t_in_item random_packet();
        logic [7:0]  proto;
        logic [31:0] addr;
        case ($urandom_range(0, 19))
            0, 1, 2: proto = 8'($urandom_range(0, 255));
            default: proto = $urandom_range(0, 1) ? PROTO_ICMP : PROTO_TCP;
        endcase
        addr = ($urandom_range(0, 3) == 0) ? $urandom() : src_pool[$urandom_range(0, 5)];
        case ($urandom_range(0, 39))
            0:       now_clock = $urandom();
            1, 2:    now_clock = now_clock + $urandom_range(0, 70000);
            default: now_clock = now_clock + $urandom_range(0, 2);
        endcase
        return make_packet(proto, addr, now_clock);
    endfunction

    task automatic random_phase(logic [15:0] thr, logic [15:0] win, bit with_idle);
        write_config(thr, win);
        for (int i = 0; i < 6; i += 2) begin
            src_pool[i]     = $urandom();
            src_pool[i + 1] = src_pool[i] ^ ALIAS_BIT;
        end
        for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            // Alternate stretches with and without idling.
            idling = with_idle && ((k / 50) % 2 == 0);
            send_packet(random_packet());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_packets();

        random_phase(16'd4, 16'd5, 1'b1);
        now_clock = 32'hFFFF_FF80;
        random_phase(16'd1, 16'd0, 1'b1);
        random_phase(16'd0, 16'd3, 1'b1);

        // Last part runs without idling on either side.
        idling = 1'b0;
        random_phase(16'd7, 16'd20, 1'b0);
        idling = 1'b0;

        drain();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (sb.expected_verdicts.size() != 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.expected_verdicts.size()));
        if (sb.mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
